// ----- sv/wrfs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the weighted random face select core.
// Holds field widths, codes, state type and parameter defaults; depends on nothing.
package wrfs_pkg;

    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int INDEX_W  = 4;
    localparam int WEIGHT_W = 16;
    localparam int RAND_W   = 31;
    localparam int FACE_W   = 5;
    localparam int STATUS_W = 2;

    localparam int DEF_MAX_FACES   = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // The remainder unit retires one bit of the random word per cycle.
    localparam int                    DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(RAND_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD     = 2'd0,
        MODE_UNIFORM  = 2'd1,
        MODE_WEIGHTED = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_WEIGHTED = 2'd0,
        ST_UNIFORM  = 2'd1,
        ST_FALLBACK = 2'd2,
        ST_BADCOUNT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_WALK,
        S_DONE
    } t_state;

endpackage

// ----- sv/wrfs_wtab.sv -----
`timescale 1ns / 1ps
// Weight table: one write port, one registered read port, per-entry valid bits.
// Depends on wrfs_pkg.
module wrfs_wtab
    import wrfs_pkg::*;
#(
    parameter int MAX_FACES   = DEF_MAX_FACES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    localparam int IDX_W      = $clog2(MAX_FACES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [IDX_W-1:0]       i_wr_addr,
    input  logic [WEIGHT_BITS-1:0] i_wr_data,
    input  logic [IDX_W-1:0]       i_rd_addr,
    output logic [WEIGHT_BITS-1:0] o_rd_data
);

    logic [WEIGHT_BITS-1:0] r_mem [MAX_FACES];
    logic [MAX_FACES-1:0]   r_valid;
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic                   r_rd_ok;

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_ok   <= r_valid[i_rd_addr];
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

// ----- sv/wrfs_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: random word modulo a divisor, one bit a cycle.
// Depends on wrfs_pkg.
module wrfs_div
    import wrfs_pkg::*;
#(
    parameter int SUM_W = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAND_W-1:0] i_dividend,
    input  logic [SUM_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [SUM_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RAND_W-1:0]    r_dvd;
    logic [SUM_W-1:0]     r_dvs;
    logic [SUM_W-1:0]     r_rem;
    logic [SUM_W-1:0]     n_rem;
    logic [SUM_W:0]       shifted;

    always_comb begin
        shifted = {r_rem, r_dvd[RAND_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = SUM_W'(shifted - {1'b0, r_dvs});
        end else begin
            n_rem = shifted[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RAND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- sv/weighted_random_face_select_core.sv -----
`timescale 1ns / 1ps
// A load request writes the weight table as it is taken; a roll with a bad face count goes
// straight to the done state. A uniform roll runs the 31-step bit-serial remainder unit.
// A weighted roll makes one pass over the weight table to total the weights (a zero weight
// falls back to a uniform roll), the remainder unit, then a second pass to find the face.
// One request is worked on at a time; a new one is taken while a result waits to be taken.
// Reset (synchronous, active low) makes all weights read as zero and empties the output register.
module weighted_random_face_select_core
    import wrfs_pkg::*;
#(
    parameter int MAX_FACES   = DEF_MAX_FACES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [COUNT_W-1:0]  i_face_count,
    input  logic [INDEX_W-1:0]  i_face_index,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic [RAND_W-1:0]   i_random_word,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [FACE_W-1:0]   o_face,
    output logic [STATUS_W-1:0] o_status
);

    // Table address width, width of a face counter that can hold the face count itself,
    // and width of a running sum of weights, which can never overflow it.
    localparam int IDX_W = $clog2(MAX_FACES);
    localparam int CNT_W = $clog2(MAX_FACES + 1);
    localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_FACES);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    n_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [SUM_W-1:0]    r_total;
    logic [SUM_W-1:0]    n_total;
    t_status             r_kind;
    t_status             n_kind;
    logic [FACE_W-1:0]   r_res_face;
    logic [FACE_W-1:0]   n_res_face;
    logic [RAND_W-1:0]   r_rnd;

    logic                r_out_valid;
    logic [FACE_W-1:0]   r_out_face;
    t_status             r_out_status;

    logic                accept;
    logic                count_bad;
    logic                last_face;
    logic                out_load;
    t_mode               mode;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W+4:0]    idx_face;
    logic [SUM_W:0]      rem_face;
    logic [SUM_W-1:0]    sum_next;

    logic                wr_en;
    logic [WEIGHT_BITS-1:0] rd_weight;
    logic                div_start;
    logic [RAND_W-1:0]   div_dividend;
    logic [SUM_W-1:0]    div_divisor;
    logic                div_done;
    logic [SUM_W-1:0]    div_rem;

    // Requests are taken only between rolls; a finished result moves to the output register,
    // so the next request waits for the consumer only while an earlier result is stalled there.
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign mode     = t_mode'(i_mode);
    assign count_bad = (i_face_count == '0) || (int'(i_face_count) > MAX_FACES);

    assign idx_inc   = r_idx + 1'b1;
    assign last_face = (idx_inc == r_cnt);
    assign idx_face  = (CNT_W + 5)'(r_idx) + 1'b1;
    assign rem_face  = {1'b0, div_rem} + 1'b1;
    assign sum_next  = r_total + SUM_W'(rd_weight);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // A uniform roll starts the remainder unit at the accept edge, straight from the
    // port. A weighted roll or a fallback starts it later, from the word registered
    // at the accept edge, as the port is free to change once the request is taken.
    assign div_dividend = (r_state == S_IDLE) ? i_random_word : r_rnd;

    // A load whose face index lies outside the table is dropped.
    assign wr_en = accept && (mode == MODE_LOAD) && (int'(i_face_index) < MAX_FACES);

    wrfs_wtab #(
        .MAX_FACES   (MAX_FACES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_wtab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_face_index)),
        .i_wr_data (WEIGHT_BITS'(i_weight)),
        .i_rd_addr (n_idx[IDX_W-1:0]),
        .o_rd_data (rd_weight)
    );

    wrfs_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (mode == MODE_UNIFORM || mode == MODE_WEIGHTED)) begin
                    if (count_bad) begin
                        n_state = S_DONE;
                    end else if (mode == MODE_UNIFORM) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (rd_weight == '0 || last_face) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = (r_kind == ST_WEIGHTED) ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (div_rem < sum_next || last_face) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control. The table read address is the next face index, so the weight
    // of the current face is on the read port throughout each pass.
    always_comb begin
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_kind      = r_kind;
        n_res_face  = r_res_face;
        div_start   = 1'b0;
        div_divisor = SUM_W'(r_cnt);
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept && (mode == MODE_UNIFORM || mode == MODE_WEIGHTED)) begin
                    n_cnt   = CNT_W'(i_face_count);
                    n_total = '0;
                    if (count_bad) begin
                        n_kind     = ST_BADCOUNT;
                        n_res_face = FACE_W'(1);
                    end else if (mode == MODE_UNIFORM) begin
                        n_kind      = ST_UNIFORM;
                        div_start   = 1'b1;
                        div_divisor = SUM_W'(i_face_count);
                    end else begin
                        n_kind = ST_WEIGHTED;
                    end
                end
            end
            S_SUM: begin
                if (rd_weight == '0) begin
                    n_kind      = ST_FALLBACK;
                    div_start   = 1'b1;
                    div_divisor = SUM_W'(r_cnt);
                end else if (last_face) begin
                    n_total     = sum_next;
                    div_start   = 1'b1;
                    div_divisor = sum_next;
                end else begin
                    n_total = sum_next;
                    n_idx   = idx_inc;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_idx   = '0;
                    n_total = '0;
                    n_res_face = rem_face[FACE_W-1:0];
                end
            end
            S_WALK: begin
                n_total = sum_next;
                if (div_rem < sum_next) begin
                    n_res_face = idx_face[FACE_W-1:0];
                end else if (last_face) begin
                    n_res_face = FACE_W'(r_cnt);
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_DONE: begin
                n_idx = r_idx;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_total    <= n_total;
        r_kind     <= n_kind;
        r_res_face <= n_res_face;
        if (accept) begin
            r_rnd <= i_random_word;
        end
        if (out_load) begin
            r_out_face   <= r_res_face;
            r_out_status <= r_kind;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_face   = r_out_face;
    assign o_status = r_out_status;

    // The remainder unit only reports completion while the controller waits for it.
    a_div_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder unit finished outside the divide state");

    // A new result appears only as the controller leaves its done state.
    a_out_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("output register loaded outside the done state");

    // The second pass over the table belongs to a weighted roll that did not fall back.
    a_walk_weighted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_kind == ST_WEIGHTED))
        else $error("table walk entered for a roll that is not weighted");

    // A bad face count always answers face one.
    a_badcount_face : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_BADCOUNT)) |-> (o_face == FACE_W'(1)))
        else $error("bad face count answered with a face other than one");

    // Requests are refused for the whole of a roll.
    a_stall_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM || r_state == S_DIV || r_state == S_WALK) |-> o_stall)
        else $error("request taken during a roll");

endmodule
